// ----- rtl/pmd_pkg.sv -----
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the PID motor drive
// Fixed field widths, fixed-point formats, register map and the control
// bundle between the sequencer and the serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int BASE_W  = 10;   // baseline register
    localparam int GAIN_W  = 24;   // Q16.8 gains
    localparam int INTEG_W = 22;   // integrator and its clamps
    localparam int SCALE_W = 16;   // Q0.16 output scale
    localparam int PID_W   = 32;   // integer PID value
    localparam int FRAC_W  = 8;    // fraction bits of the term sum
    localparam int DIGIT_W = 4;    // multiplier digit per cycle
    localparam int ADDR_W  = 5;    // APB byte address
    localparam int DATA_W  = 32;   // APB data

    typedef enum logic [2:0] {
        REG_BASELINE   = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_INTEG_LOW  = 3'd4,
        REG_INTEG_HIGH = 3'd5,
        REG_OUT_SCALE  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic load;   // take new operands and start a pass
        logic clr;    // clear the accumulator on load
    } t_mac_ctrl;

endpackage

// ----- rtl/pmd_serial_mac.sv -----
// ----------------------------------------------------------------------------
// pmd_serial_mac: digit-serial multiply-accumulate
// Adds a signed multiplicand times an unsigned multiplier into an
// accumulator, one multiplier digit per cycle, least significant first.
// ----------------------------------------------------------------------------
module pmd_serial_mac #(
    parameter int ACC_W = 49
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pmd_pkg::t_mac_ctrl          i_ctrl,
    input  logic signed [ACC_W-1:0]     i_mcand,
    input  logic [pmd_pkg::GAIN_W-1:0]  i_mplier,
    output logic signed [ACC_W-1:0]     o_acc,
    output logic                        o_busy
);
    import pmd_pkg::*;

    localparam int DIGITS = GAIN_W / DIGIT_W;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    logic signed [ACC_W-1:0]  r_mcand;
    logic [GAIN_W-1:0]        r_mplier;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_pp;

    // partial product of one digit; wraps modulo 2^ACC_W, the final sum fits
    assign w_pp = ACC_W'(r_mcand * $signed({1'b0, r_mplier[DIGIT_W-1:0]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.load) begin
            r_cnt <= CNT_W'(DIGITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            if (i_ctrl.clr) begin
                r_acc <= '0;
            end
        end else if (r_cnt != '0) begin
            r_acc    <= r_acc + w_pp;
            r_mcand  <= r_mcand <<< DIGIT_W;
            r_mplier <= r_mplier >> DIGIT_W;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = (r_cnt != '0);

endmodule

// ----- rtl/pid_motor_drive_unit.sv -----
// ----------------------------------------------------------------------------
// pid_motor_drive_unit: PID drive command for one wheel
// Integrator with clamps, P/I/D terms on a shared digit-serial multiplier,
// then the scaled and saturated motor command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one reflectance sample per request (i_in_valid/o_in_ready).
//   Output channel: drive command and PID value (o_out_valid/i_out_ready).
//   Config: APB-style port, register i at byte address 4*i; write only while
//   the block is idle. pready is tied high, reads return the register value.
// Timing:
//   A request is taken only in the idle state. It runs through the integrator
//   step, the P, I and D multiplier passes, rounding and saturation, and the
//   output scale pass: four passes on the shared 4-bit-digit multiplier. The
//   next request is taken only after the result has been registered and the
//   block is back in idle.
// Reset:
//   Clears the integrator and previous sample, loads default gains and
//   scale, drops any pending result.
// Stall:
//   The result sits in an output register; the block takes and processes the
//   next request while it waits, and holds a second result until the first
//   has been taken.
// ----------------------------------------------------------------------------
module pid_motor_drive_unit #(
    parameter int SAMPLE_BITS = 10,
    parameter int CMD_MAX     = 4095
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample request
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [SAMPLE_BITS-1:0]             i_sensor_sample,
    // result
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [$clog2(CMD_MAX+1)-1:0]       o_drive_command,
    output logic signed [pmd_pkg::PID_W-1:0]   o_pid_value,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pmd_pkg::ADDR_W-1:0]         paddr,
    input  logic [pmd_pkg::DATA_W-1:0]         pwdata,
    output logic [pmd_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import pmd_pkg::*;

    localparam int CMD_W  = $clog2(CMD_MAX + 1);
    localparam int ERR_W  = ((SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W) + 1;
    localparam int IADD_W = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
    localparam int ACC_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + GAIN_W + 3;
    localparam int QUO_W  = ACC_W - FRAC_W;
    localparam int T_W    = PID_W + 2;

    localparam logic signed [QUO_W-1:0] Q_MAX =
        {{(QUO_W-PID_W+1){1'b0}}, {(PID_W-1){1'b1}}};
    localparam logic signed [QUO_W-1:0] Q_MIN =
        {{(QUO_W-PID_W+1){1'b1}}, {(PID_W-1){1'b0}}};
    localparam logic signed [T_W-1:0]   T_MAX = T_W'(65535);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_INTEG  = 13'b0_0000_0000_0010,
        S_LOAD_P = 13'b0_0000_0000_0100,
        S_MUL_P  = 13'b0_0000_0000_1000,
        S_LOAD_I = 13'b0_0000_0001_0000,
        S_MUL_I  = 13'b0_0000_0010_0000,
        S_LOAD_D = 13'b0_0000_0100_0000,
        S_MUL_D  = 13'b0_0000_1000_0000,
        S_QUOT   = 13'b0_0001_0000_0000,
        S_SAT    = 13'b0_0010_0000_0000,
        S_LOAD_S = 13'b0_0100_0000_0000,
        S_MUL_S  = 13'b0_1000_0000_0000,
        S_OUT    = 13'b1_0000_0000_0000
    } t_state;

    // configuration registers
    logic [BASE_W-1:0]         r_baseline;
    logic [GAIN_W-1:0]         r_gain_p;
    logic [GAIN_W-1:0]         r_gain_i;
    logic [GAIN_W-1:0]         r_gain_d;
    logic signed [INTEG_W-1:0] r_integ_low;
    logic signed [INTEG_W-1:0] r_integ_high;
    logic [SCALE_W-1:0]        r_out_scale;

    // state and datapath
    t_state                    r_state, n_state;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic [SAMPLE_BITS-1:0]    r_prev;
    logic [SAMPLE_BITS-1:0]    r_samp;
    logic signed [QUO_W-1:0]   r_quot;
    logic signed [PID_W-1:0]   r_pid;
    logic                      r_out_valid;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [PID_W-1:0]   r_out_pid;

    logic                      w_cfg_wr;
    t_reg_idx                  w_idx;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W-1:0]   w_dmeas;
    logic signed [IADD_W-1:0]  w_isum;
    logic signed [IADD_W-1:0]  w_iclip;
    logic signed [ACC_W-1:0]   w_round;
    logic signed [T_W-1:0]     w_t;
    logic [SCALE_W-1:0]        w_t16;
    logic [SCALE_W-1:0]        w_cmd_full;
    logic                      w_out_free;

    t_mac_ctrl                 w_mac_ctrl;
    logic signed [ACC_W-1:0]   w_mcand;
    logic [GAIN_W-1:0]         w_mplier;
    logic signed [ACC_W-1:0]   w_acc;
    logic                      w_busy;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline   <= '0;
            r_gain_p     <= GAIN_W'(102400);
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_integ_low  <= '0;
            r_integ_high <= '0;
            r_out_scale  <= SCALE_W'(328);
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_BASELINE:   r_baseline   <= pwdata[BASE_W-1:0];
                REG_GAIN_P:     r_gain_p     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:     r_gain_i     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:     r_gain_d     <= pwdata[GAIN_W-1:0];
                REG_INTEG_LOW:  r_integ_low  <= pwdata[INTEG_W-1:0];
                REG_INTEG_HIGH: r_integ_high <= pwdata[INTEG_W-1:0];
                REG_OUT_SCALE:  r_out_scale  <= pwdata[SCALE_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    // read back; signed clamps come back sign-extended
    always_comb begin
        case (w_idx)
            REG_BASELINE:   prdata = DATA_W'(r_baseline);
            REG_GAIN_P:     prdata = DATA_W'(r_gain_p);
            REG_GAIN_I:     prdata = DATA_W'(r_gain_i);
            REG_GAIN_D:     prdata = DATA_W'(r_gain_d);
            REG_INTEG_LOW:  prdata = DATA_W'(r_integ_low);
            REG_INTEG_HIGH: prdata = DATA_W'(r_integ_high);
            REG_OUT_SCALE:  prdata = DATA_W'(r_out_scale);
            default:        prdata = '0;
        endcase
    end

    // ---------------- error, integrator, derivative ----------------
    assign w_err   = ERR_W'($signed({1'b0, r_samp})) - ERR_W'($signed({1'b0, r_baseline}));
    assign w_dmeas = ERR_W'($signed({1'b0, r_prev})) - ERR_W'($signed({1'b0, r_samp}));
    assign w_isum  = IADD_W'(r_integ) + IADD_W'(w_err);

    // clamp high first, low last, so crossed limits settle on the low one
    always_comb begin
        w_iclip = w_isum;
        if (w_iclip > IADD_W'(r_integ_high)) begin
            w_iclip = IADD_W'(r_integ_high);
        end
        if (w_iclip < IADD_W'(r_integ_low)) begin
            w_iclip = IADD_W'(r_integ_low);
        end
        n_integ = INTEG_W'(w_iclip);
    end

    // ---------------- integer part and command input ----------------
    // truncate toward zero: bias negative sums before the arithmetic shift
    assign w_round = w_acc[ACC_W-1] ? (w_acc + ACC_W'((1 << FRAC_W) - 1)) : w_acc;

    assign w_t = T_MAX - T_W'(r_pid);
    always_comb begin
        if (w_t > T_MAX) begin
            w_t16 = '1;
        end else if (w_t[T_W-1] || (w_t == '0)) begin
            w_t16 = '0;   // a negative difference floors at zero
        end else begin
            w_t16 = w_t[SCALE_W-1:0];
        end
    end

    assign w_cmd_full = w_acc[2*SCALE_W-1:SCALE_W];

    // ---------------- multiplier operand selection ----------------
    always_comb begin
        w_mac_ctrl = '0;
        w_mcand    = ACC_W'(w_err);
        w_mplier   = r_gain_p;
        case (r_state)
            S_LOAD_P: begin
                w_mac_ctrl.load = 1'b1;
                w_mac_ctrl.clr  = 1'b1;
            end
            S_LOAD_I: begin
                w_mac_ctrl.load = 1'b1;
                w_mcand         = ACC_W'(r_integ);
                w_mplier        = r_gain_i;
            end
            S_LOAD_D: begin
                w_mac_ctrl.load = 1'b1;
                w_mcand         = ACC_W'(w_dmeas);
                w_mplier        = r_gain_d;
            end
            S_LOAD_S: begin
                w_mac_ctrl.load = 1'b1;
                w_mac_ctrl.clr  = 1'b1;
                w_mcand         = ACC_W'($signed({1'b0, w_t16}));
                w_mplier        = GAIN_W'(r_out_scale);
            end
            default: ;
        endcase
    end

    pmd_serial_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_acc    (w_acc),
        .o_busy   (w_busy)
    );

    // ---------------- sequencer ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_INTEG;
            S_INTEG:  n_state = S_LOAD_P;
            S_LOAD_P: n_state = S_MUL_P;
            S_MUL_P:  if (!w_busy) n_state = S_LOAD_I;
            S_LOAD_I: n_state = S_MUL_I;
            S_MUL_I:  if (!w_busy) n_state = S_LOAD_D;
            S_LOAD_D: n_state = S_MUL_D;
            S_MUL_D:  if (!w_busy) n_state = S_QUOT;
            S_QUOT:   n_state = S_SAT;
            S_SAT:    n_state = S_LOAD_S;
            S_LOAD_S: n_state = S_MUL_S;
            S_MUL_S:  if (!w_busy) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INTEG) begin
                r_integ <= n_integ;
            end
            // advance the previous sample once the derivative operand is taken
            if (r_state == S_LOAD_D) begin
                r_prev <= r_samp;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_samp <= i_sensor_sample;
        end
        if (r_state == S_QUOT) begin
            r_quot <= QUO_W'(w_round >>> FRAC_W);
        end
        if (r_state == S_SAT) begin
            if (r_quot > Q_MAX) begin
                r_pid <= PID_W'(Q_MAX);
            end else if (r_quot < Q_MIN) begin
                r_pid <= PID_W'(Q_MIN);
            end else begin
                r_pid <= PID_W'(r_quot);
            end
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_pid <= r_pid;
            if (w_cmd_full > SCALE_W'(CMD_MAX)) begin
                r_cmd <= CMD_W'(CMD_MAX);
            end else begin
                r_cmd <= CMD_W'(w_cmd_full);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_command = r_cmd;
    assign o_pid_value     = r_out_pid;

endmodule
